[sv/ebm_pkg.sv]
package ebm_pkg;

   // default sizes, handed down through the top level parameters
   localparam int RING_DEPTH_DEF  = 8;
   localparam int NUM_CLASSES_DEF = 3;

   localparam int CLASS_W = 2;
   localparam int TIME_W  = 32;
   localparam int COUNT_W = 32;

   // register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   typedef enum logic [1:0] {
      REG_BURST_WINDOW = 2'd0,
      REG_REPORT_GAP   = 2'd1,
      REG_HEAL_PRESET  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [CLASS_W-1:0] error_class;
      logic [TIME_W-1:0]  event_time;
   } req_type;

   typedef struct packed {
      logic               report_issued;
      logic               heal_triggered;
      logic [COUNT_W-1:0] class_count;
   } rsp_type;

   // request after the front end has looked at it
   typedef struct packed {
      logic               class_ok;
      logic [CLASS_W-1:0] error_class;
      logic [TIME_W-1:0]  event_time;
   } job_type;

   typedef struct packed {
      logic [TIME_W-1:0] burst_window;
      logic [TIME_W-1:0] report_gap;
      logic              heal_preset;
   } cfg_type;

endpackage

[sv/ebm_csr.sv]
module ebm_csr
   import ebm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx    = reg_index_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_BURST_WINDOW: cfg_in.burst_window = csr_pwdata;
            REG_REPORT_GAP:   cfg_in.report_gap   = csr_pwdata;
            REG_HEAL_PRESET:  cfg_in.heal_preset  = csr_pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_BURST_WINDOW: csr_prdata = cfg_ff.burst_window;
         REG_REPORT_GAP:   csr_prdata = cfg_ff.report_gap;
         REG_HEAL_PRESET:  csr_prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.heal_preset};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_window <= TIME_W'(60);
         cfg_ff.report_gap   <= TIME_W'(3600);
         cfg_ff.heal_preset  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/ebm_front.sv]
module ebm_front
   import ebm_pkg::*;
#(
   parameter int NUM_CLASSES = NUM_CLASSES_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    job_valid,
   output job_type job,
   input  logic    job_pop
);

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;
   logic       pop_ok;
   job_type    new_job;

   assign req_full  = (cnt_ff == 2'd2);
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_pop && job_valid;

   // classes beyond the configured set are flagged here and pass through untouched
   always_comb begin
      new_job.class_ok    = (32'(req_data.error_class) < NUM_CLASSES);
      new_job.error_class = req_data.error_class;
      new_job.event_time  = req_data.event_time;
   end

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= new_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[sv/ebm_back.sv]
module ebm_back
   import ebm_pkg::*;
#(
   parameter int RING_DEPTH  = RING_DEPTH_DEF,
   parameter int NUM_CLASSES = NUM_CLASSES_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    job_valid,
   input  job_type job,
   output logic    job_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int PTR_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int ENTRIES = NUM_CLASSES * RING_DEPTH;
   localparam int RAM_AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   typedef enum logic {
      S_IDLE,
      S_FINISH
   } state_type;

   state_type state_ff;

   // per class state
   logic [COUNT_W-1:0] count_ff [NUM_CLASSES];
   logic [PTR_W-1:0]   ptr_ff   [NUM_CLASSES];
   logic [TIME_W-1:0]  last_ff  [NUM_CLASSES];
   logic               full_ff  [NUM_CLASSES];
   logic               heal_done_ff;

   // timestamp rings, all classes in one memory
   logic [TIME_W-1:0] ring_mem [ENTRIES];
   logic [TIME_W-1:0] ring_rd_ff;

   // held between the two steps
   logic               report_ff;
   logic [COUNT_W-1:0] res_count_ff;
   logic               oldest_ok_ff;
   logic [TIME_W-1:0]  time_ff;

   // result queue
   rsp_type    out_q_ff [2];
   logic       out_wr_ff;
   logic       out_rd_ff;
   logic [1:0] out_cnt_ff;
   logic       out_push;
   logic       out_pop;
   rsp_type    out_item;

   logic               take;
   logic [CLS_W-1:0]   cls_idx;
   logic [COUNT_W-1:0] cnt_cur, cnt_nxt;
   logic [PTR_W-1:0]   ptr_cur, ptr_nxt;
   logic [TIME_W-1:0]  last_cur;
   logic               full_nxt;
   logic               recent;
   logic               report;
   logic [RAM_AW-1:0]  base_addr;
   logic [RAM_AW-1:0]  wr_addr;
   logic [RAM_AW-1:0]  rd_addr;
   logic               heal;

   assign take    = (state_ff == S_IDLE) && job_valid && (out_cnt_ff != 2'd2);
   assign job_pop = take;

   assign cls_idx  = CLS_W'(job.error_class);
   assign cnt_cur  = count_ff[cls_idx];
   assign ptr_cur  = ptr_ff[cls_idx];
   assign last_cur = last_ff[cls_idx];

   always_comb begin
      cnt_nxt = cnt_cur + COUNT_W'(1);
      // slot follows count mod depth, also across the 32-bit wrap
      if (cnt_nxt == '0) begin
         ptr_nxt = '0;
      end else if (ptr_cur == PTR_W'(RING_DEPTH - 1)) begin
         ptr_nxt = '0;
      end else begin
         ptr_nxt = ptr_cur + PTR_W'(1);
      end
      // slot about to be reused has been written once the ring has gone round
      full_nxt = full_ff[cls_idx] || (ptr_cur == PTR_W'(RING_DEPTH - 1));
   end

   always_comb begin
      recent = (last_cur != '0) &&
               ((job.event_time < last_cur) ||
                ((job.event_time - last_cur) < cfg.report_gap));
      report = !recent && !((job.error_class == '0) && (job.event_time == '0));
   end

   assign base_addr = RAM_AW'(cls_idx) * RAM_AW'(RING_DEPTH);
   assign wr_addr   = base_addr + RAM_AW'(ptr_cur);
   assign rd_addr   = base_addr + RAM_AW'(ptr_nxt);

   always_ff @(posedge clock) begin
      if (take && job.class_ok) begin
         ring_mem[wr_addr] <= job.event_time;
      end
      ring_rd_ff <= ring_mem[rd_addr];
   end

   always_comb begin
      heal = oldest_ok_ff && (ring_rd_ff != '0) && (time_ff != '0) &&
             ((time_ff < ring_rd_ff) || ((time_ff - ring_rd_ff) <= cfg.burst_window)) &&
             !cfg.heal_preset && !heal_done_ff;
      out_item.report_issued  = report_ff;
      out_item.heal_triggered = heal;
      out_item.class_count    = res_count_ff;
   end

   assign out_push  = (state_ff == S_FINISH);
   assign out_pop   = rsp_pop && (out_cnt_ff != 2'd0);
   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp_data  = out_q_ff[out_rd_ff];

   always_ff @(posedge clock) begin
      if (take) begin
         report_ff    <= job.class_ok && report;
         res_count_ff <= job.class_ok ? cnt_nxt : '0;
         oldest_ok_ff <= job.class_ok && full_nxt;
         time_ff      <= job.event_time;
      end
      if (out_push) begin
         out_q_ff[out_wr_ff] <= out_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heal_done_ff <= 1'b0;
         out_wr_ff    <= 1'b0;
         out_rd_ff    <= 1'b0;
         out_cnt_ff   <= 2'd0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            count_ff[i] <= '0;
            ptr_ff[i]   <= '0;
            last_ff[i]  <= '0;
            full_ff[i]  <= 1'b0;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (take) begin
                  state_ff <= S_FINISH;
                  if (job.class_ok) begin
                     count_ff[cls_idx] <= cnt_nxt;
                     ptr_ff[cls_idx]   <= ptr_nxt;
                     full_ff[cls_idx]  <= full_nxt;
                     if (report) begin
                        last_ff[cls_idx] <= job.event_time;
                     end
                  end
               end
            end
            S_FINISH: begin
               state_ff <= S_IDLE;
               if (heal) begin
                  heal_done_ff <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (out_push) begin
            out_wr_ff <= ~out_wr_ff;
         end
         if (out_pop) begin
            out_rd_ff <= ~out_rd_ff;
         end
         out_cnt_ff <= out_cnt_ff + 2'(out_push) - 2'(out_pop);
      end
   end

endmodule

[sv/error_burst_monitor.sv]
// channel   direction  handshake               payload
// req       in         req_push / req_full     req_data    (error_class, event_time)
// rsp       out        rsp_empty / rsp_pop     rsp_data    (report_issued, heal_triggered,
//                                                            class_count)
// csr       in/out     apb, csr_pready tied 1  csr_paddr / csr_pwdata / csr_prdata
//
// each request passes through two back-end steps: the first updates the class counters
// and writes the ring slot while the oldest slot is read, the second decides on healing
// from the registered read data; a new request is taken only after the last one is done
// reset is synchronous; no clearing pass, ring slots count as empty until the
// class ring has gone round once, so the block takes requests right after reset
// a 2-entry request queue and a 2-entry result queue let either side stall alone
module error_burst_monitor
   import ebm_pkg::*;
#(
   parameter int RING_DEPTH  = RING_DEPTH_DEF,
   parameter int NUM_CLASSES = NUM_CLASSES_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_push,
   output logic                  req_full,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output rsp_type               rsp_data,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   logic    job_valid;
   job_type job;
   logic    job_pop;

   // burst window, report gap and heal preset
   ebm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // front end: accepts requests, flags unknown classes, queues them
   ebm_front #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop)
   );

   // back end: per class counters, timestamp rings, report and heal decision
   ebm_back #(
      .RING_DEPTH  (RING_DEPTH),
      .NUM_CLASSES (NUM_CLASSES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
